FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an implication holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/tdq_pkg.sv
package tdq_pkg;

    localparam int Capacity = 16;
    localparam int IdBits   = 8;
    localparam int PosBits  = $clog2(Capacity);
    localparam int OccBits  = $clog2(Capacity + 1);

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REMOVE_ID  = 3'd4,
        OP_TAKE_FRONT = 3'd5,
        OP_TAKE_BACK  = 3'd6,
        OP_NONE       = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] entry_id;
        logic [3:0] entry_state;
        logic       entry_tied;
        logic [5:0] entry_proc;
        logic [3:0] want_state;
        logic [5:0] want_proc;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] out_id;
        logic [3:0] out_state;
        logic       out_tied;
        logic [5:0] out_proc;
        logic [4:0] occupancy;
    } t_out_item;

    typedef struct packed {
        logic [IdBits-1:0] id;
        logic [3:0]        state;
        logic              tied;
        logic [5:0]        proc;
    } t_entry;

    // Controller to datapath.
    typedef struct packed {
        logic load;    // capture the input item
        logic exec;    // perform the operation and build the result
    } t_cmd;

endpackage

FILE: hw/rtl/tdq_ctrl.sv
module tdq_ctrl
    import tdq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_EXEC;
            S_EXEC: n_state = S_OUT;
            S_OUT: begin
                if (!i_out_stall) n_state = i_in_valid ? S_EXEC : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Take the next item when idle or as the current result leaves; hold off during reset.
    assign o_in_stall  = !i_rst_n ||
                         !((r_state == S_IDLE) || (r_state == S_OUT && !i_out_stall));
    assign o_out_valid = (r_state == S_OUT);
    assign o_cmd.load  = i_in_valid && !o_in_stall;
    assign o_cmd.exec  = (r_state == S_EXEC);

    `include "assert_macros.svh"
    `ASSERT_NEXT(a_load_exec, i_clk, i_rst_n, o_cmd.load, o_cmd.exec, "load without exec")
    `ASSERT_NEXT(a_exec_out, i_clk, i_rst_n, o_cmd.exec, o_out_valid, "exec without result")
    `ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_cmd.exec, !o_out_valid, "exec during output")

endmodule

FILE: hw/rtl/tdq_dpath.sv
module tdq_dpath
    import tdq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_item,
    output t_out_item o_item
);

    t_entry            r_slot [Capacity];
    logic [OccBits-1:0] r_fill;
    t_in_item          r_req;
    t_out_item         r_res;
    t_out_item         n_res;

    logic [Capacity-1:0] hit;
    logic                found;
    logic [PosBits-1:0]  pos;
    logic                do_rm, do_push, full;
    t_entry              nw;
    t_opcode             op;

    assign op   = t_opcode'(r_req.opcode);
    assign full = (r_fill == OccBits'(Capacity));
    assign nw   = '{id: r_req.entry_id[IdBits-1:0], state: r_req.entry_state,
                    tied: r_req.entry_tied, proc: r_req.entry_proc};

    // Compare every live slot against the request.
    always_comb begin
        for (int k = 0; k < Capacity; k++) begin
            logic live, fits;
            live = (OccBits'(k) < r_fill);
            fits = (r_slot[k].state == r_req.want_state) &&
                   (!r_slot[k].tied || r_slot[k].proc == r_req.want_proc);
            case (op)
                OP_POP_FRONT:  hit[k] = live && (k == 0);
                OP_POP_BACK:   hit[k] = live && (OccBits'(k + 1) == r_fill);
                OP_REMOVE_ID:  hit[k] = live && (r_slot[k].id == r_req.entry_id[IdBits-1:0]);
                OP_TAKE_FRONT,
                OP_TAKE_BACK:  hit[k] = live && fits;
                default:       hit[k] = 1'b0;
            endcase
        end
    end

    // Priority pick from the chosen end.
    always_comb begin
        found = |hit;
        pos   = '0;
        if (op == OP_TAKE_BACK) begin
            for (int k = 0; k < Capacity; k++) if (hit[k]) pos = PosBits'(k);
        end else begin
            for (int k = Capacity - 1; k >= 0; k--) if (hit[k]) pos = PosBits'(k);
        end
    end

    assign do_rm   = i_cmd.exec && found;
    assign do_push = i_cmd.exec && !full &&
                     (op == OP_PUSH_BACK || op == OP_PUSH_FRONT);

    // Build the result of the current request.
    always_comb begin
        n_res           = '0;
        n_res.occupancy = 5'(r_fill);
        if (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) begin
            if (full) begin
                n_res.status = ST_FULL;
            end else begin
                n_res.status    = ST_DONE;
                n_res.occupancy = 5'(r_fill + 1'b1);
            end
        end else if (found) begin
            n_res.status    = ST_DONE;
            n_res.out_id    = 8'(r_slot[pos].id);
            n_res.out_state = r_slot[pos].state;
            n_res.out_tied  = r_slot[pos].tied;
            n_res.out_proc  = r_slot[pos].proc;
            n_res.occupancy = 5'(r_fill - 1'b1);
        end else begin
            n_res.status = ST_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_item;
        if (do_push) begin
            if (op == OP_PUSH_BACK) begin
                r_slot[r_fill[PosBits-1:0]] <= nw;
            end else begin
                for (int k = Capacity - 1; k > 0; k--) r_slot[k] <= r_slot[k-1];
                r_slot[0] <= nw;
            end
        end else if (do_rm) begin
            // Close the gap toward the front.
            for (int k = 0; k < Capacity - 1; k++)
                if (PosBits'(k) >= pos) r_slot[k] <= r_slot[k+1];
        end
        if (i_cmd.exec) r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)     r_fill <= '0;
        else if (do_push) r_fill <= r_fill + 1'b1;
        else if (do_rm)   r_fill <= r_fill - 1'b1;
    end

    assign o_item = r_res;

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_fill_max, i_clk, i_rst_n, 1'b1, r_fill <= OccBits'(Capacity), "fill overflow")
    `ASSERT_IMPL(a_rm_live, i_clk, i_rst_n, do_rm, OccBits'(pos) < r_fill, "removal past fill")
    `ASSERT_NEXT(a_push_grow, i_clk, i_rst_n, do_push, r_fill == $past(r_fill) + 1'b1,
                 "push did not grow fill")

endmodule

FILE: hw/rtl/task_deque_filtered_dequeue.sv
// Ordered ready queue of task descriptors, up to 16 entries, front at slot 0.
// Input channel: i_in_valid / o_in_stall with an i_in_item struct carrying
// opcode (push back/front, pop front/back, remove by id, filtered take from
// front or back), the descriptor to push and the wanted state/processor.
// Output channel: o_out_valid / i_out_stall with an o_out_item struct:
// status (done, empty or no match, full), the removed descriptor (zero when
// nothing was removed) and the occupancy after the operation.
// An accepted item is executed in state S_EXEC, which compares all slots in
// parallel, picks by priority and shifts the slot array; its result is then
// held in S_OUT. The next item is taken at the edge where the current result
// leaves, so no new item is taken while a result is still pending.
// A filtered take matches entries whose state equals the wanted state and
// that are untied or tied to the wanted processor.
// Reset (synchronous, active low) stalls the input, empties the queue and
// drops any pending result; slot contents are not cleared and are never read.
// While the receiver stalls the result is held and new items are stalled.
module task_deque_filtered_dequeue
    import tdq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_cmd cmd;

    // Sequence load, execute and hold.
    tdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // Hold the slots and perform the operation.
    tdq_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_in_item),
        .o_item  (o_out_item)
    );

endmodule

FILE: test/tb_task_deque_filtered_dequeue.sv
module tb_task_deque_filtered_dequeue;
    timeunit 1ns;
    timeprecision 1ps;

    import tdq_pkg::*;

    localparam int Depth = 16;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    task_deque_filtered_dequeue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the ready queue, front at index 0.
    t_entry    shadow_q[$];
    t_out_item pending_results[$];
    int        mismatch_count = 0;
    bit        stim_done = 1'b0;
    bit        hold_output = 1'b0;   // long receiver hold-off
    int        idle_pct = 29;

    // Directed rows: item plus a typed result where it is obvious.
    typedef struct {
        t_in_item  item;
        bit        has_fixed;
        t_out_item fixed;
    } t_dir_row;

    function automatic bit entry_matches(t_entry e, logic [3:0] ws, logic [5:0] wp);
        return (e.state == ws) && (!e.tied || e.proc == wp);
    endfunction

    // Compute the queue result and update the shadow queue.
    function automatic t_out_item apply_queue_op(t_in_item it);
        t_out_item r;
        t_entry    e;
        int        pos;
        r = '0;
        r.status = ST_EMPTY;
        pos = -1;
        e.id = it.entry_id;
        e.state = it.entry_state;
        e.tied = it.entry_tied;
        e.proc = it.entry_proc;
        case (t_opcode'(it.opcode))
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (shadow_q.size() >= Depth) begin
                    r.status = ST_FULL;
                end else begin
                    if (it.opcode == OP_PUSH_BACK) shadow_q.push_back(e);
                    else shadow_q.push_front(e);
                    r.status = ST_DONE;
                end
            end
            OP_POP_FRONT: if (shadow_q.size() > 0) pos = 0;
            OP_POP_BACK:  if (shadow_q.size() > 0) pos = shadow_q.size() - 1;
            OP_REMOVE_ID: begin
                for (int i = 0; i < shadow_q.size(); i++)
                    if (pos < 0 && shadow_q[i].id == it.entry_id) pos = i;
            end
            OP_TAKE_FRONT: begin
                for (int i = 0; i < shadow_q.size(); i++)
                    if (pos < 0 && entry_matches(shadow_q[i], it.want_state, it.want_proc))
                        pos = i;
            end
            OP_TAKE_BACK: begin
                for (int i = shadow_q.size() - 1; i >= 0; i--)
                    if (pos < 0 && entry_matches(shadow_q[i], it.want_state, it.want_proc))
                        pos = i;
            end
            default: ;
        endcase
        if (pos >= 0) begin
            r.status = ST_DONE;
            r.out_id = shadow_q[pos].id;
            r.out_state = shadow_q[pos].state;
            r.out_tied = shadow_q[pos].tied;
            r.out_proc = shadow_q[pos].proc;
            shadow_q.delete(pos);
        end
        r.occupancy = 5'(shadow_q.size());
        return r;
    endfunction

    function automatic t_in_item make_item(t_opcode op, logic [7:0] id, logic [3:0] st,
                                           logic tied, logic [5:0] pr,
                                           logic [3:0] ws, logic [5:0] wp);
        t_in_item it;
        it.opcode = op;
        it.entry_id = id;
        it.entry_state = st;
        it.entry_tied = tied;
        it.entry_proc = pr;
        it.want_state = ws;
        it.want_proc = wp;
        return it;
    endfunction

    function automatic t_out_item make_result(t_status s, logic [4:0] occ);
        t_out_item r;
        r = '0;
        r.status = s;
        r.occupancy = occ;
        return r;
    endfunction

    // Offer one item, with random idle cycles ahead of it; hold until accepted.
    task automatic send_item(t_in_item it, bit has_fixed, t_out_item fixed);
        t_out_item pred;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = apply_queue_op(it);
        if (has_fixed && pred != fixed) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("directed row disagrees with predictor: %h vs %h", fixed, pred);
        end
        pending_results.push_back(pred);
    endtask

    task automatic drop_valid();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random item, biased toward ids and states that actually hit.
    function automatic t_in_item random_item();
        t_in_item it;
        int       sel;
        it = '0;
        sel = $urandom_range(99);
        if (sel < 40) it.opcode = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        else if (sel < 97) it.opcode = 3'($urandom_range(2, 6));
        else it.opcode = OP_NONE;
        it.entry_id = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
        it.entry_state = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(2));
        it.entry_tied = 1'($urandom_range(1));
        it.entry_proc = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(2));
        it.want_state = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(2));
        it.want_proc = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(2));
        return it;
    endfunction

    // Stimulus.
    initial begin
        t_dir_row dir_rows[$];
        t_dir_row row;
        t_out_item none;
        none = '0;
        // Empty queue: every removal and the no-op report empty.
        row.has_fixed = 1; row.item = make_item(OP_POP_FRONT, 0, 0, 0, 0, 0, 0);
        row.fixed = make_result(ST_EMPTY, 0); dir_rows.push_back(row);
        row.item = make_item(OP_POP_BACK, 0, 0, 0, 0, 0, 0); dir_rows.push_back(row);
        row.item = make_item(OP_REMOVE_ID, 8'hff, 0, 0, 0, 0, 0); dir_rows.push_back(row);
        row.item = make_item(OP_TAKE_FRONT, 0, 0, 0, 0, 4'hf, 6'h3f); dir_rows.push_back(row);
        row.item = make_item(OP_TAKE_BACK, 0, 0, 0, 0, 0, 0); dir_rows.push_back(row);
        row.item = make_item(OP_NONE, 8'hff, 4'hf, 1, 6'h3f, 4'hf, 6'h3f);
        dir_rows.push_back(row);
        // Extremes pushed, with a duplicate id, then filtered takes, removals by id and pops.
        row.item = make_item(OP_PUSH_BACK, 8'hff, 4'hf, 1, 6'h3f, 0, 0);
        row.fixed = make_result(ST_DONE, 1); dir_rows.push_back(row);
        row.item = make_item(OP_PUSH_FRONT, 8'h00, 4'h0, 0, 6'h00, 0, 0);
        row.fixed = make_result(ST_DONE, 2); dir_rows.push_back(row);
        row.has_fixed = 0;
        row.item = make_item(OP_PUSH_BACK, 8'hff, 4'h5, 0, 6'h2a, 0, 0); dir_rows.push_back(row);
        row.item = make_item(OP_PUSH_BACK, 8'h55, 4'hf, 1, 6'h15, 0, 0); dir_rows.push_back(row);
        row.item = make_item(OP_TAKE_FRONT, 0, 0, 0, 0, 4'hf, 6'h15); dir_rows.push_back(row);
        row.item = make_item(OP_TAKE_BACK, 0, 0, 0, 0, 4'hf, 6'h3f); dir_rows.push_back(row);
        row.item = make_item(OP_TAKE_BACK, 0, 0, 0, 0, 4'h3, 6'h00); dir_rows.push_back(row);
        row.item = make_item(OP_REMOVE_ID, 8'hff, 0, 0, 0, 0, 0); dir_rows.push_back(row);
        row.item = make_item(OP_REMOVE_ID, 8'h77, 0, 0, 0, 0, 0); dir_rows.push_back(row);
        row.item = make_item(OP_POP_BACK, 0, 0, 0, 0, 0, 0); dir_rows.push_back(row);
        row.item = make_item(OP_POP_FRONT, 0, 0, 0, 0, 0, 0); dir_rows.push_back(row);
        // Fill to capacity, then one refused push.
        for (int i = 0; i < Depth; i++) begin
            row.item = make_item(OP_PUSH_BACK, 8'(i), 4'(i), 1'(i), 6'(i), 0, 0);
            dir_rows.push_back(row);
        end
        row.has_fixed = 1;
        row.item = make_item(OP_PUSH_FRONT, 8'h99, 4'h9, 1, 6'h09, 0, 0);
        row.fixed = make_result(ST_FULL, 5'(Depth)); dir_rows.push_back(row);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) send_item(dir_rows[k].item, dir_rows[k].has_fixed,
                                        dir_rows[k].fixed);
        for (int n = 0; n < 400; n++) begin
            // Long stretch without idling on either side.
            idle_pct = (n >= 100 && n < 160) ? 0 : 29;
            if (n == 200) begin
                // Pause until the queue of results drains.
                drop_valid();
                while (pending_results.size() > 0) @(posedge i_clk);
            end
            if (n == 250) hold_output = 1'b1;
            send_item(random_item(), 0, none);
        end
        i_in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stalls plus one long hold-off counted here.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_output && hold_left == 0) begin
                hold_left = 60;
                hold_output = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= (idle_pct > 0) && ($urandom_range(99) < idle_pct);
            end
        end
    end

    // Compare each delivered result with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", o_out_item);
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.status !== want.status ||
                    o_out_item.out_id !== want.out_id ||
                    o_out_item.out_state !== want.out_state ||
                    o_out_item.out_tied !== want.out_tied ||
                    o_out_item.out_proc !== want.out_proc ||
                    o_out_item.occupancy !== want.occupancy) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %h got %h", want, o_out_item);
                end
            end
        end
    end

    // Drain, then keep watching for stray results before the verdict.
    initial begin
        wait (stim_done);
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
